[rtl/core/trq_pkg.sv]
`default_nettype none

package trq_pkg;

  // Fixed payload widths of the two channels
  localparam int unsigned OP_W     = 3;
  localparam int unsigned TID_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_PEEK    = 3'd3,
    OP_CLEAR   = 3'd4
  } trq_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } trq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } trq_state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;      // latch request, snapshot empty/full
    logic push;       // append id at tail
    logic clear;      // drop all entries
    logic walk_init;  // rewind the walk pointers
    logic walk;       // one step of the scan/compact pass
    logic emit;       // load the result register
  } trq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    trq_op_e op;
    logic    empty;
    logic    full;
    logic    walk_done;
  } trq_sts_t;

endpackage

`default_nettype wire

[rtl/core/trq_in_if.sv]
`default_nettype none

interface trq_in_if;
  logic                       valid;
  logic                       ready;
  logic [trq_pkg::OP_W-1:0]   opcode;
  logic [trq_pkg::TID_W-1:0]  thread_id;

  modport source (output valid, output opcode, output thread_id, input ready);
  modport sink   (input valid, input opcode, input thread_id, output ready);
endinterface

`default_nettype wire

[rtl/core/trq_out_if.sv]
`default_nettype none

interface trq_out_if;
  logic                          valid;
  logic                          ready;
  logic [trq_pkg::TID_W-1:0]     out_thread_id;
  logic [trq_pkg::STATUS_W-1:0]  status;
  logic [trq_pkg::OCC_W-1:0]     occupancy;

  modport source (output valid, output out_thread_id, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input out_thread_id, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/trq_ctrl.sv]
`default_nettype none

module trq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire trq_pkg::trq_sts_t sts_i,
  output trq_pkg::trq_cmd_t      cmd_o
);

  trq_pkg::trq_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      trq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = trq_pkg::S_EXEC;
        end
      end
      trq_pkg::S_EXEC: begin
        state_d = trq_pkg::S_DONE;
        case (sts_i.op)
          trq_pkg::OP_ENQUEUE: begin
            cmd_o.push = !sts_i.full;
          end
          trq_pkg::OP_DEQUEUE, trq_pkg::OP_REMOVE, trq_pkg::OP_PEEK: begin
            if (!sts_i.empty) begin
              cmd_o.walk_init = 1'b1;
              state_d         = trq_pkg::S_WALK;
            end
          end
          trq_pkg::OP_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      trq_pkg::S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_d = trq_pkg::S_DONE;
        end
      end
      trq_pkg::S_DONE: begin
        // wait for the result register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = trq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = trq_pkg::S_IDLE;
      end
    endcase
  end

  // Result beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // a pending beat is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (out_valid_o && state_q == trq_pkg::S_IDLE))
    else $error("emit did not raise result valid");

  // an accepted beat always starts execution
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == trq_pkg::S_EXEC))
    else $error("accepted beat not executed");

endmodule

`default_nettype wire

[rtl/core/trq_dp.sv]
`default_nettype none

module trq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [trq_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [trq_pkg::TID_W-1:0]     thread_id_i,
  input  wire trq_pkg::trq_cmd_t             cmd_i,
  output trq_pkg::trq_sts_t                  sts_o,
  output logic [trq_pkg::TID_W-1:0]          out_thread_id_o,
  output logic [trq_pkg::STATUS_W-1:0]       status_o,
  output logic [trq_pkg::OCC_W-1:0]          occupancy_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Entry store, head at position 0
  logic [ID_BITS-1:0] mem [QUEUE_DEPTH];

  logic [CW-1:0]      count_q, count_d;
  trq_pkg::trq_op_e   op_q;
  logic [ID_BITS-1:0] id_q;
  logic               empty_q, full_q;
  logic               found_q, found_d;
  logic [ID_BITS-1:0] res_id_q;
  logic [CW-1:0]      rd_ptr_q, rd_ptr_d;
  logic               dv_q, dv_d;
  logic [IW-1:0]      didx_q, didx_d;
  logic [ID_BITS-1:0] rdata_q;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic               head_mode, drop_mode, hit, walk_done;
  trq_pkg::trq_status_e status_c;

  assign head_mode = (op_q == trq_pkg::OP_DEQUEUE) || (op_q == trq_pkg::OP_PEEK);
  assign drop_mode = (op_q == trq_pkg::OP_DEQUEUE) || (op_q == trq_pkg::OP_REMOVE);

  // Element under test: head position or an id match, first one only
  assign hit = dv_q && !found_q && (head_mode ? (didx_q == '0) : (rdata_q == id_q));

  assign walk_done = (rd_ptr_q == count_q && !dv_q) ||
                     (found_q && op_q == trq_pkg::OP_PEEK);

  // Walk: issue one read a cycle, test or shift down what came back
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    dv_d     = dv_q;
    didx_d   = didx_q;
    found_d  = found_q;
    if (cmd_i.start) begin
      found_d = 1'b0;
    end
    if (cmd_i.walk_init) begin
      rd_ptr_d = '0;
      dv_d     = 1'b0;
    end else if (cmd_i.walk) begin
      if (hit) begin
        found_d = 1'b1;
      end
      if (rd_ptr_q < count_q) begin
        dv_d     = 1'b1;
        didx_d   = rd_ptr_q[IW-1:0];
        rd_ptr_d = rd_ptr_q + 1'b1;
      end else begin
        dv_d = 1'b0;
      end
    end
  end

  // Single write port: tail append or compaction
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IW-1:0];
    mem_wdata = id_q;
    if (cmd_i.push) begin
      mem_we = 1'b1;
    end else if (cmd_i.walk && dv_q && found_q && drop_mode) begin
      mem_we    = 1'b1;
      mem_waddr = didx_q - 1'b1;
      mem_wdata = rdata_q;
    end
  end

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.walk && walk_done && found_q && drop_mode) begin
      count_d = count_q - 1'b1;
    end
  end

  // Result status
  always_comb begin
    status_c = trq_pkg::ST_OK;
    case (op_q)
      trq_pkg::OP_ENQUEUE: begin
        if (full_q) status_c = trq_pkg::ST_FULL;
      end
      trq_pkg::OP_DEQUEUE, trq_pkg::OP_PEEK: begin
        if (empty_q) status_c = trq_pkg::ST_EMPTY;
      end
      trq_pkg::OP_REMOVE: begin
        if (empty_q) begin
          status_c = trq_pkg::ST_EMPTY;
        end else if (!found_q) begin
          status_c = trq_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_c = trq_pkg::ST_OK;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      found_q  <= 1'b0;
      dv_q     <= 1'b0;
      rd_ptr_q <= '0;
    end else begin
      count_q  <= count_d;
      found_q  <= found_d;
      dv_q     <= dv_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    didx_q <= didx_d;
    if (cmd_i.start) begin
      op_q    <= trq_pkg::trq_op_e'(opcode_i);
      id_q    <= ID_BITS'(thread_id_i);
      empty_q <= (count_q == '0);
      full_q  <= (count_q == DEPTH_C);
    end
    if (cmd_i.walk && hit) begin
      res_id_q <= rdata_q;
    end
    if (cmd_i.emit) begin
      out_thread_id_o <= found_q ? trq_pkg::TID_W'(res_id_q) : '0;
      status_o        <= status_c;
      occupancy_o     <= trq_pkg::OCC_W'(count_q);
    end
  end

  // Memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_ptr_q[IW-1:0]];
  end

  assign sts_o.op        = op_q;
  assign sts_o.empty     = empty_q;
  assign sts_o.full      = full_q;
  assign sts_o.walk_done = walk_done;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("occupancy beyond depth");

  // compaction writes only follow the removed element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && cmd_i.walk) |-> (found_q && drop_mode && didx_q != '0))
    else $error("shift write before a match");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (count_q != '0 && $past(count_q) != DEPTH_C))
    else $error("push on a full queue");

endmodule

`default_nettype wire

[rtl/core/thread_ready_queue_top.sv]
// Sequence: enqueue, clear, unused opcodes and any op on an empty queue go from S_EXEC to
//   S_DONE; dequeue, remove and peek pass through S_WALK in between, scanning the held entries.
// A new item is accepted only in S_IDLE, once the previous result is loaded for output.
// The scan/compact pass reads and rewrites the entry memory one position per cycle.
// The next item is taken while a result still waits; reset (async, active low) empties the queue.
`default_nettype none

module thread_ready_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  trq_in_if.sink      req_i,
  trq_out_if.source   rsp_o
);

  trq_pkg::trq_cmd_t cmd;
  trq_pkg::trq_sts_t sts;

  // Sequencer
  trq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Entry store and result datapath
  trq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (req_i.opcode),
    .thread_id_i     (req_i.thread_id),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_thread_id_o (rsp_o.out_thread_id),
    .status_o        (rsp_o.status),
    .occupancy_o     (rsp_o.occupancy)
  );

endmodule

`default_nettype wire
